// File: hdl/sorted_stack_kway_merge_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the sorted stack k-way merge checker.
// They sample on clk; all but the reset check are disabled during rst.
// ---------------------------------------------------------------------------
`ifndef SORTED_STACK_KWAY_MERGE_ASSERT_SVH
`define SORTED_STACK_KWAY_MERGE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SSKM_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sskm assertion failed");

// antecedent implies consequent in the next cycle
`define SSKM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sskm assertion failed");

// next-cycle implication that is also checked while rst is high
`define SSKM_ASSERT_RST(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sskm reset assertion failed");

`endif

// File: hdl/sskm_pkg.sv
// ---------------------------------------------------------------------------
// sskm_pkg
// Shared constants and types of the sorted stack k-way merge block.
// ---------------------------------------------------------------------------
package sskm_pkg;

  // default configuration
  localparam int NUM_STACKS_DEF  = 8;
  localparam int STACK_DEPTH_DEF = 8;
  localparam int VALUE_WIDTH_DEF = 32;

  // fixed port widths
  localparam int STACK_IDX_W = 3;
  localparam int OUT_W       = 32;

  // largest signed 32-bit value, seed of the running minimum
  localparam logic signed [31:0] INT_MAX = 32'sh7fff_ffff;

  // operation codes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_MERGE = 1'b1;

  // controls of the shared minimum unit
  typedef struct packed {
    logic                   clear;
    logic                   cmp_en;
    logic [STACK_IDX_W-1:0] cmp_idx;
  } sskm_min_ctl_t;

  // flags of one result item
  typedef struct packed {
    logic last;
    logic empty;
    logic ovf;
  } sskm_flags_t;

endpackage

// File: hdl/sskm_store.sv
// ---------------------------------------------------------------------------
// sskm_store
// Value memory of all stacks: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module sskm_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [WIDTH-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic signed [WIDTH-1:0] rdata
);

  logic signed [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data in the next cycle
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/sskm_min_unit.sv
// ---------------------------------------------------------------------------
// sskm_min_unit
// Shared signed comparator with running minimum and the stack that holds it.
// A strict less-than keeps the lowest stack on ties.
// ---------------------------------------------------------------------------
module sskm_min_unit #(
  parameter int VALUE_WIDTH = sskm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  sskm_pkg::sskm_min_ctl_t             ctl,
  input  logic signed [VALUE_WIDTH-1:0]       cand,
  output logic signed [VALUE_WIDTH-1:0]       best,
  output logic [sskm_pkg::STACK_IDX_W-1:0]    best_idx
);

  localparam logic signed [VALUE_WIDTH-1:0] SEED =
    VALUE_WIDTH'(sskm_pkg::INT_MAX >>> (32 - VALUE_WIDTH));

  logic found;

  // compare one candidate per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.cmp_en && (!found || cand < best)) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      best     <= SEED;
      best_idx <= '0;
    end else if (ctl.cmp_en && (!found || cand < best)) begin
      best     <= cand;
      best_idx <= ctl.cmp_idx;
    end
  end

endmodule

// File: hdl/sskm_ctrl.sv
// ---------------------------------------------------------------------------
// sskm_ctrl
// Sequencer: stack heights, merge cursors, top-of-stack scan and results.
// ---------------------------------------------------------------------------
module sskm_ctrl #(
  parameter int NUM_STACKS  = sskm_pkg::NUM_STACKS_DEF,
  parameter int STACK_DEPTH = sskm_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = sskm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input items
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [sskm_pkg::STACK_IDX_W-1:0]    stack_index,
  input  logic signed [31:0]                  push_value,
  // result items
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic signed [VALUE_WIDTH-1:0]       res_value,
  output sskm_pkg::sskm_flags_t               res_flags
);

  localparam int IW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
  localparam int PW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int HW    = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH = NUM_STACKS * STACK_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int TW    = $clog2(DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_LAST = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                         state;
  logic [HW-1:0]                  heights [NUM_STACKS];
  logic [HW-1:0]                  cur     [NUM_STACKS];
  logic [TW-1:0]                  total;
  logic [TW-1:0]                  remaining;
  logic [IW-1:0]                  scan_idx;
  logic                           p_valid;
  logic [sskm_pkg::STACK_IDX_W-1:0] p_idx;
  logic                           emit_merge;
  logic                           res_empty;
  logic                           res_ovf;

  logic                           accept;
  logic                           idx_ok;
  logic [IW-1:0]                  sel_idx;
  logic [HW-1:0]                  sel_height;
  logic                           push_ok;
  logic                           we;
  logic [AW-1:0]                  waddr;
  logic                           re;
  logic [AW-1:0]                  raddr;
  logic [HW-1:0]                  scan_cur;
  logic [HW-1:0]                  scan_pos;
  logic signed [VALUE_WIDTH-1:0]  rdata;
  logic signed [VALUE_WIDTH-1:0]  best;
  logic [sskm_pkg::STACK_IDX_W-1:0] best_idx;
  logic [IW-1:0]                  best_sel;
  logic                           emit_fire;
  sskm_pkg::sskm_min_ctl_t        min_ctl;

  function automatic logic [AW-1:0] addr_of(input logic [IW-1:0] stk,
                                            input logic [PW-1:0] pos);
    int a;
    a = int'(stk) * STACK_DEPTH + int'(pos);
    return AW'(a);
  endfunction

  // push decode
  assign accept     = in_valid && in_ready;
  assign idx_ok     = (4'(stack_index) < 4'(NUM_STACKS));
  assign sel_idx    = idx_ok ? stack_index[IW-1:0] : '0;
  assign sel_height = heights[sel_idx];
  assign push_ok    = idx_ok && (sel_height != HW'(STACK_DEPTH));
  assign we         = accept && (op == sskm_pkg::OP_PUSH) && push_ok;
  assign waddr      = addr_of(sel_idx, sel_height[PW-1:0]);

  // scan read of one stack top per cycle
  assign scan_cur = cur[scan_idx];
  assign scan_pos = scan_cur - HW'(1);
  assign re       = (state == S_SCAN) && (scan_cur != '0);
  assign raddr    = addr_of(scan_idx, scan_pos[PW-1:0]);

  sskm_store #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (push_value[VALUE_WIDTH-1:0]),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // minimum unit control
  assign min_ctl.clear   = (state == S_SCAN) && (scan_idx == '0);
  assign min_ctl.cmp_en  = p_valid;
  assign min_ctl.cmp_idx = p_idx;

  sskm_min_unit #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_min (
    .clk      (clk),
    .rst      (rst),
    .ctl      (min_ctl),
    .cand     (rdata),
    .best     (best),
    .best_idx (best_idx)
  );

  assign best_sel = best_idx[IW-1:0];

  // result outputs
  assign in_ready        = (state == S_IDLE);
  assign res_valid       = (state == S_EMIT);
  assign emit_fire       = res_valid && res_ready;
  assign res_value       = emit_merge ? best : '0;
  assign res_flags.last  = emit_merge ? (remaining == TW'(1)) : 1'b1;
  assign res_flags.empty = res_empty;
  assign res_flags.ovf   = res_ovf;

  // read pipeline tag
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= re;
    end
  end

  always_ff @(posedge clk) begin
    p_idx <= sskm_pkg::STACK_IDX_W'(scan_idx);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      total      <= '0;
      remaining  <= '0;
      scan_idx   <= '0;
      emit_merge <= 1'b0;
      res_empty  <= 1'b0;
      res_ovf    <= 1'b0;
      for (int s = 0; s < NUM_STACKS; s++) begin
        heights[s] <= '0;
        cur[s]     <= '0;
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (op == sskm_pkg::OP_PUSH) begin
              emit_merge <= 1'b0;
              res_empty  <= 1'b0;
              res_ovf    <= !push_ok;
              if (push_ok) begin
                heights[sel_idx] <= sel_height + HW'(1);
                total            <= total + TW'(1);
              end
              state <= S_EMIT;
            end else if (total == '0) begin
              emit_merge <= 1'b0;
              res_empty  <= 1'b1;
              res_ovf    <= 1'b0;
              state      <= S_EMIT;
            end else begin
              emit_merge <= 1'b1;
              res_empty  <= 1'b0;
              res_ovf    <= 1'b0;
              remaining  <= total;
              scan_idx   <= '0;
              for (int s = 0; s < NUM_STACKS; s++) begin
                cur[s] <= heights[s];
              end
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_idx == IW'(NUM_STACKS - 1)) begin
            state <= S_LAST;
          end else begin
            scan_idx <= scan_idx + IW'(1);
          end
        end
        S_LAST: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (emit_fire) begin
            if (emit_merge) begin
              cur[best_sel] <= cur[best_sel] - HW'(1);
              remaining     <= remaining - TW'(1);
              scan_idx      <= '0;
              state         <= (remaining == TW'(1)) ? S_IDLE : S_SCAN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hdl/sorted_stack_kway_merge.sv
// ---------------------------------------------------------------------------
// sorted_stack_kway_merge
// Bounded signed stacks with push and ascending k-way merge read-out.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries op, stack_index and push_value.
// A push stores push_value on the chosen stack and gives one item with
// is_last set, out_value zero and overflow set if the stack was full or the
// index was out of range. A merge walks the stacks and gives every stored
// value, smallest top first, lowest stack on ties, the last item marked;
// with nothing stored it gives one item with is_empty and is_last set.
// The stacks are left unchanged by a merge.
// A push item passes from the sequencer's emit state into the output
// register, and in_ready returns in the same cycle that it shows on
// out_valid, so pushes are taken one at a time. Each merged value takes
// one memory read per stack top through the single read port into the
// shared comparator, a step to drain the last read and a step to emit.
// in_ready stays low until the last item of the merge is emitted.
// When out_ready is low the output register holds its item and the
// sequencer waits; nothing is lost. Synchronous rst empties all stacks and
// clears out_valid of the output register; no clearing pass is needed.
// ---------------------------------------------------------------------------
module sorted_stack_kway_merge #(
  parameter int NUM_STACKS  = sskm_pkg::NUM_STACKS_DEF,
  parameter int STACK_DEPTH = sskm_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = sskm_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                op,
  input  logic [sskm_pkg::STACK_IDX_W-1:0]    stack_index,
  input  logic signed [31:0]                  push_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [sskm_pkg::OUT_W-1:0]   out_value,
  output logic                                is_last,
  output logic                                is_empty,
  output logic                                overflow
);

  logic                          res_valid;
  logic                          res_ready;
  logic signed [VALUE_WIDTH-1:0] res_value;
  sskm_pkg::sskm_flags_t         res_flags;

  sskm_ctrl #(
    .NUM_STACKS  (NUM_STACKS),
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .stack_index (stack_index),
    .push_value  (push_value),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res_value   (res_value),
    .res_flags   (res_flags)
  );

  // output register, free when empty or being taken
  assign res_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_value <= sskm_pkg::OUT_W'(res_value);
      is_last   <= res_flags.last;
      is_empty  <= res_flags.empty;
      overflow  <= res_flags.ovf;
    end
  end

endmodule

// File: hdl/sskm_checker.sv
// ---------------------------------------------------------------------------
// sskm_checker
// Port-level checks of the sorted stack k-way merge, bound to the top.
// ---------------------------------------------------------------------------
`include "sorted_stack_kway_merge_assert.svh"

module sskm_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic signed [sskm_pkg::OUT_W-1:0] out_value,
  input logic                              is_last,
  input logic                              is_empty,
  input logic                              overflow
);

  // one item at a time: ready drops once an item is taken
  `SSKM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // a dropped push is a single, zero-valued, final item
  `SSKM_ASSERT_SAME(a_ovf_item, out_valid && overflow,
                    is_last && !is_empty && out_value == '0)

  // an empty merge is a single, zero-valued, final item
  `SSKM_ASSERT_SAME(a_empty_item, out_valid && is_empty,
                    is_last && !overflow && out_value == '0)

  // stalled output item holds
  `SSKM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_value) && $stable(is_last))

  // reset empties the output register
  `SSKM_ASSERT_RST(a_reset_clears, rst, !out_valid)

endmodule

bind sorted_stack_kway_merge sskm_checker u_sskm_checker (.*);

// File: tb/sv/tb_sorted_stack_kway_merge.sv
// ---------------------------------------------------------------------------
// tb_sorted_stack_kway_merge
// Self-checking bench for the sorted stack k-way merge block. It pushes
// descending runs of random values onto random stacks, mixed with stray
// values and merges. It also fills stack 4 until a push overflows. A
// scoreboard object keeps its own copy of the stacks, predicts every result
// item and compares the DUT output with it field by field. Both handshakes
// idle at random. The receiver also holds off once for a long spell, so that
// the block backs up and stalls its input.
// ---------------------------------------------------------------------------
module tb_sorted_stack_kway_merge;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NS = sskm_pkg::NUM_STACKS_DEF;
  localparam int SD = sskm_pkg::STACK_DEPTH_DEF;
  localparam int VW = sskm_pkg::VALUE_WIDTH_DEF;

  localparam int RANDOM_ITEMS = 230;
  localparam int HOLD_CYCLES  = 600;
  localparam int STALL_LIMIT  = 5000;

  // one result item as the block should produce it
  typedef struct packed {
    logic signed [sskm_pkg::OUT_W-1:0] value;
    sskm_pkg::sskm_flags_t             flags;
  } merge_out_t;

  // scoreboard: private copy of the stacks plus the queue of awaited results
  class merge_checker;
    logic signed [VW-1:0] stack_mem [NS][SD];
    int unsigned          depth_of [NS];
    merge_out_t           awaited [$];
    int unsigned          fails;

    function new();
      foreach (depth_of[s]) depth_of[s] = 0;
      fails = 0;
    endfunction

    // predict the result items of one accepted input item
    function void note_input(logic op_in, logic [sskm_pkg::STACK_IDX_W-1:0] idx,
                             logic signed [31:0] val);
      int unsigned          cur [NS];
      int unsigned          remaining;
      int                   best;
      logic signed [VW-1:0] best_val;
      merge_out_t           r;
      r.value       = '0;
      r.flags.last  = 1'b1;
      r.flags.empty = 1'b0;
      r.flags.ovf   = 1'b0;
      // push: store unless the stack is full or out of range
      if (op_in == sskm_pkg::OP_PUSH) begin
        r.flags.ovf = 1'b1;
        if (idx < NS && depth_of[idx] < SD) begin
          stack_mem[idx][depth_of[idx]] = val[VW-1:0];
          depth_of[idx]++;
          r.flags.ovf = 1'b0;
        end
        awaited.push_back(r);
        return;
      end
      // merge: read-only walk over all stack tops
      remaining = 0;
      foreach (cur[s]) begin
        cur[s] = depth_of[s];
        remaining += depth_of[s];
      end
      if (remaining == 0) begin
        r.flags.empty = 1'b1;
        awaited.push_back(r);
        return;
      end
      while (remaining > 0) begin
        best     = -1;
        best_val = '0;
        // strict less-than keeps the lowest stack on ties
        for (int s = 0; s < NS; s++) begin
          if (cur[s] > 0 && (best < 0 || stack_mem[s][cur[s]-1] < best_val)) begin
            best     = s;
            best_val = stack_mem[s][cur[s]-1];
          end
        end
        cur[best]--;
        remaining--;
        r.value      = best_val;
        r.flags.last = (remaining == 0);
        awaited.push_back(r);
      end
    endfunction

    // compare one accepted result item with the oldest prediction
    function void check_result(logic signed [sskm_pkg::OUT_W-1:0] v, logic last,
                               logic empty, logic ovf);
      merge_out_t e;
      if (awaited.size() == 0) begin
        $error("result item with nothing pending: out_value %0d", v);
        fails++;
        return;
      end
      e = awaited.pop_front();
      if (v !== e.value) begin
        $error("out_value expected %0d actual %0d", e.value, v);
        fails++;
      end
      if (last !== e.flags.last) begin
        $error("is_last expected %0d actual %0d", e.flags.last, last);
        fails++;
      end
      if (empty !== e.flags.empty) begin
        $error("is_empty expected %0d actual %0d", e.flags.empty, empty);
        fails++;
      end
      if (ovf !== e.flags.ovf) begin
        $error("overflow expected %0d actual %0d", e.flags.ovf, ovf);
        fails++;
      end
    endfunction
  endclass

  logic                              clk;
  logic                              rst;
  logic                              in_valid;
  logic                              in_ready;
  logic                              op;
  logic [sskm_pkg::STACK_IDX_W-1:0]  stack_index;
  logic signed [31:0]                push_value;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [sskm_pkg::OUT_W-1:0] out_value;
  logic                              is_last;
  logic                              is_empty;
  logic                              overflow;

  merge_checker chk = new();

  // stimulus-side view of the stacks, used to build descending runs
  longint      run_top [NS];
  int unsigned run_cnt [NS];
  logic        tx_steady;

  sorted_stack_kway_merge i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .op          (op),
    .stack_index (stack_index),
    .push_value  (push_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_value   (out_value),
    .is_last     (is_last),
    .is_empty    (is_empty),
    .overflow    (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // monitor: sample both channels on the edge, before the DUT updates
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) chk.note_input(op, stack_index, push_value);
      if (out_valid && out_ready) chk.check_result(out_value, is_last, is_empty, overflow);
    end
  end

  // offer one item and wait until it is taken
  task automatic send_item(input logic o, input logic [sskm_pkg::STACK_IDX_W-1:0] idx,
                           input logic signed [31:0] v);
    while (!tx_steady && $urandom_range(0, 99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    op          <= o;
    stack_index <= idx;
    push_value  <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (o == sskm_pkg::OP_PUSH && run_cnt[idx] < SD) begin
      run_top[idx] = v;
      run_cnt[idx]++;
    end
  endtask

  // receiver: random back-pressure, one long hold-off, then a steady spell
  initial begin : receiver
    int unsigned cyc;
    int unsigned hold_left;
    cyc       = 0;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc == 1500) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (cyc >= 3000 && cyc < 6000) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 15);
      end
    end
  end

  // watchdog: too long without any item moving on either side
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int unsigned          filled;
    int unsigned          idx;
    longint               nv;
    logic signed [31:0]   v;
    rst         <= 1'b1;
    in_valid    <= 1'b0;
    op          <= sskm_pkg::OP_PUSH;
    stack_index <= '0;
    push_value  <= '0;
    tx_steady   = 1'b0;
    foreach (run_cnt[s]) begin
      run_cnt[s] = 0;
      run_top[s] = 0;
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // merge with nothing stored
    send_item(sskm_pkg::OP_MERGE, '0, '0);
    // value extremes on the outer stacks
    send_item(sskm_pkg::OP_PUSH, 3'd0, sskm_pkg::INT_MAX);
    send_item(sskm_pkg::OP_PUSH, 3'd7, 32'sh8000_0000);
    send_item(sskm_pkg::OP_MERGE, 3'd7, 32'sh7fff_ffff);
    // equal tops on three stacks: lowest stack goes first
    send_item(sskm_pkg::OP_PUSH, 3'd1, 32'sd5);
    send_item(sskm_pkg::OP_PUSH, 3'd2, 32'sd5);
    send_item(sskm_pkg::OP_PUSH, 3'd3, 32'sd5);
    send_item(sskm_pkg::OP_MERGE, '0, '0);
    // fill stack 4, then one push too many
    for (int i = 0; i < SD + 1; i++) send_item(sskm_pkg::OP_PUSH, 3'd4, 32'sd100 - i);
    // tops out of order and an all-ones value
    send_item(sskm_pkg::OP_PUSH, 3'd0, -32'sd1);
    send_item(sskm_pkg::OP_PUSH, 3'd7, 32'sd0);
    send_item(sskm_pkg::OP_MERGE, '0, '0);

    // random part: mostly descending runs, some stray values, merges between
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      tx_steady = (k >= 100 && k < 150);
      filled = 0;
      foreach (run_cnt[s]) filled += run_cnt[s];
      if ($urandom_range(0, 99) < ((filled == NS * SD) ? 25 : 12)) begin
        send_item(sskm_pkg::OP_MERGE,
                  sskm_pkg::STACK_IDX_W'($urandom_range(0, NS - 1)), $urandom);
      end else begin
        idx = $urandom_range(0, NS - 1);
        if (run_cnt[idx] == 0 || $urandom_range(0, 99) < 20) begin
          v = $urandom;
        end else begin
          // small steps give ties across stacks, large ones spread values
          if ($urandom_range(0, 1)) nv = run_top[idx] - $urandom_range(0, 3);
          else nv = run_top[idx] - $urandom_range(0, 1 << 20);
          if (nv < -64'sd2147483648) nv = -64'sd2147483648;
          v = nv[31:0];
        end
        send_item(sskm_pkg::OP_PUSH, sskm_pkg::STACK_IDX_W'(idx), v);
      end
    end
    in_valid <= 1'b0;

    // drain, then allow for a late stray item
    while (chk.awaited.size() != 0) @(posedge clk);
    repeat (4 * (NS + 2)) @(posedge clk);

    if (chk.fails == 0 && chk.awaited.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
